// ===== src/spiral_setpoint_generator_assert.svh =====
// Assertion macros for the spiral setpoint generator.
`ifndef SPIRAL_SETPOINT_GENERATOR_ASSERT_SVH
`define SPIRAL_SETPOINT_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ssg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table.
package ssg_pkg;

    localparam int PHASE_BITS = 32;
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int QTR        = SINE_DEPTH / 4;
    localparam int QTR_W      = IDX_W - 2;

    localparam int POS_W  = 28;
    localparam int STEP_W = 24;
    localparam int OUT_W  = 29;
    localparam int MAG_W  = 31;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam longint SIN_ONE     = longint'(1) << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TAYLOR_DIV [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

    typedef enum logic [2:0] {
        REG_HEIGHT_LOW   = 3'd0,
        REG_HEIGHT_HIGH  = 3'd1,
        REG_HEIGHT_STEP  = 3'd2,
        REG_RADIUS_STEP  = 3'd3,
        REG_RADIUS_START = 3'd4,
        REG_RADIUS_CAP   = 3'd5,
        REG_HEIGHT_CAP   = 3'd6,
        REG_PHASE_STEP   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]  height_low;
        logic [POS_W-1:0]  height_high;
        logic [STEP_W-1:0] height_step;
        logic [STEP_W-1:0] radius_step;
        logic [POS_W-1:0]  radius_start;
        logic [POS_W-1:0]  radius_cap;
        logic [POS_W-1:0]  height_cap;
        logic [31:0]       phase_step;
    } ssg_cfg_t;

    localparam ssg_cfg_t CFG_RESET = '{
        height_low:   28'd13421773,
        height_high:  28'd41943040,
        height_step:  24'd9079,
        radius_step:  24'd6409,
        radius_start: 28'd16777216,
        radius_cap:   28'd46976205,
        height_cap:   28'd50331648,
        phase_step:   32'd6835505
    };

    localparam logic [POS_W-1:0] HEIGHT_RESET = 28'd13421773;
    localparam logic [POS_W-1:0] RADIUS_RESET = 28'd16777216;

    // one beat leaving the state update
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] radius;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] z;
        logic             desc;
    } ssg_sample_t;

    typedef struct packed {
        logic s2_valid;
    } ssg_status_t;

    typedef logic [MAG_W-1:0] sine_rom_t [QTR];

    // sin of x (Q30 radians, first quadrant), Taylor to x^13, truncating divides
    function automatic longint sin_quadrant(input longint x);
        longint x2;
        longint term;
        longint sum;
        int     i;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (i = 0; i < 6; i++) begin
            term = -(term * x2) / TAYLOR_DIV[i];
            term = term / SIN_ONE;
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > SIN_ONE) begin
            sum = SIN_ONE;
        end
        return sum;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        int        j;
        for (j = 0; j < QTR; j++) begin
            rom[j] = MAG_W'(sin_quadrant((longint'(j) * 4 * HALF_PI_Q30) / SINE_DEPTH));
        end
        return rom;
    endfunction

    localparam sine_rom_t        SINE_ROM  = build_sine_rom();
    localparam logic [MAG_W-1:0] SINE_PEAK = MAG_W'(sin_quadrant(HALF_PI_Q30));

endpackage

// ===== src/spiral_setpoint_generator.sv =====
// Spiral setpoint generator top level: config port, state update, trig pipeline.
//
//   channel | handshake            | beat payload
//   --------+----------------------+--------------------------------------
//   cfg     | psel/penable/pready  | paddr, pwdata, prdata (8 x 32-bit)
//   in      | in_valid / in_stall  | restart
//   out     | out_valid / out_stall| x_pos, y_pos, z_pos, descending
//
// One beat per cycle sustained while out_stall is low; a beat is taken into the state
// update register on the accept edge, then passes the sine lookup register, then
// multiply/round into the output register. The state registers close their loop combinationally.
// out_stall reaches in_stall combinationally; three beats fit before the input stalls.
// Reset is immediate: no clearing pass, the sine table is constant logic.
`include "spiral_setpoint_generator_assert.svh"

module spiral_setpoint_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]        paddr,
    input  logic [ssg_pkg::DATA_W-1:0]        pwdata,
    output logic [ssg_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ssg_pkg::OUT_W-1:0]  x_pos,
    output logic signed [ssg_pkg::OUT_W-1:0]  y_pos,
    output logic [ssg_pkg::POS_W-1:0]         z_pos,
    output logic                              descending
);
    import ssg_pkg::*;

    ssg_cfg_t    cfg;
    ssg_sample_t s1;
    ssg_status_t status;
    logic        s1_ready;

    ssg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssg_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .s1       (s1),
        .s1_ready (s1_ready)
    );

    ssg_trig u_trig (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1         (s1),
        .s1_ready   (s1_ready),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .z_pos      (z_pos),
        .descending (descending)
    );

    `SSG_ASSERT_IMPL(a_empty_out_no_stall, !out_valid, !in_stall, "stall with empty output")
    `SSG_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1.valid, "accepted beat lost")
    `SSG_ASSERT_NEXT(a_drain_empties_out, out_valid && !out_stall && !status.s2_valid, !out_valid, "beat invented")

endmodule

// ===== src/ssg_regs.sv =====
// APB configuration registers.
module ssg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssg_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssg_pkg::DATA_W-1:0]  pwdata,
    output logic [ssg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ssg_pkg::ssg_cfg_t           cfg
);
    import ssg_pkg::*;

    ssg_cfg_t cfg_reg;
    ssg_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_HEIGHT_LOW:   cfg_next.height_low   = pwdata[POS_W-1:0];
                REG_HEIGHT_HIGH:  cfg_next.height_high  = pwdata[POS_W-1:0];
                REG_HEIGHT_STEP:  cfg_next.height_step  = pwdata[STEP_W-1:0];
                REG_RADIUS_STEP:  cfg_next.radius_step  = pwdata[STEP_W-1:0];
                REG_RADIUS_START: cfg_next.radius_start = pwdata[POS_W-1:0];
                REG_RADIUS_CAP:   cfg_next.radius_cap   = pwdata[POS_W-1:0];
                REG_HEIGHT_CAP:   cfg_next.height_cap   = pwdata[POS_W-1:0];
                REG_PHASE_STEP:   cfg_next.phase_step   = pwdata[31:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HEIGHT_LOW:   prdata = DATA_W'(cfg_reg.height_low);
            REG_HEIGHT_HIGH:  prdata = DATA_W'(cfg_reg.height_high);
            REG_HEIGHT_STEP:  prdata = DATA_W'(cfg_reg.height_step);
            REG_RADIUS_STEP:  prdata = DATA_W'(cfg_reg.radius_step);
            REG_RADIUS_START: prdata = DATA_W'(cfg_reg.radius_start);
            REG_RADIUS_CAP:   prdata = DATA_W'(cfg_reg.radius_cap);
            REG_HEIGHT_CAP:   prdata = DATA_W'(cfg_reg.height_cap);
            REG_PHASE_STEP:   prdata = DATA_W'(cfg_reg.phase_step);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/ssg_state.sv =====
// Height/radius/phase state update and the first pipeline register.
module ssg_state (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssg_pkg::ssg_cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,
    output ssg_pkg::ssg_sample_t   s1,
    input  logic                   s1_ready
);
    import ssg_pkg::*;

    logic [POS_W-1:0]      height_reg, height_next;
    logic [POS_W-1:0]      radius_reg, radius_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  down_reg, down_next;
    ssg_sample_t           s1_reg, s1_next;

    logic [POS_W-1:0]      h_cur, r_cur;
    logic [PHASE_BITS-1:0] ph_cur;
    logic                  dn_cur, dn_new, accept;

    // step up or down, floor at zero, then cap
    function automatic logic [POS_W-1:0] step_value(
        input logic [POS_W-1:0]  cur,
        input logic [STEP_W-1:0] step,
        input logic [POS_W-1:0]  cap,
        input logic              down
    );
        logic [POS_W:0]   up_sum;
        logic [POS_W-1:0] up_cap;
        logic [POS_W-1:0] dn_val;
        logic [POS_W-1:0] dn_cap;
        up_sum = {1'b0, cur} + (POS_W+1)'(step);
        up_cap = (up_sum > {1'b0, cap}) ? cap : up_sum[POS_W-1:0];
        dn_val = (cur > POS_W'(step)) ? (cur - POS_W'(step)) : '0;
        dn_cap = (dn_val > cap) ? cap : dn_val;
        return down ? dn_cap : up_cap;
    endfunction

    assign in_stall = s1_reg.valid && !s1_ready;
    assign accept   = in_valid && !in_stall;
    assign s1       = s1_reg;

    always_comb
    begin
        h_cur  = restart ? cfg.height_low : height_reg;
        r_cur  = restart ? cfg.radius_start : radius_reg;
        ph_cur = restart ? '0 : phase_reg;
        dn_cur = restart ? 1'b0 : down_reg;

        priority if (h_cur > cfg.height_high)
            dn_new = 1'b1;
        else if (h_cur < cfg.height_low)
            dn_new = 1'b0;
        else
            dn_new = dn_cur;

        height_next = height_reg;
        radius_next = radius_reg;
        phase_next  = phase_reg;
        down_next   = down_reg;
        s1_next     = s1_reg;
        if (accept)
        begin
            height_next   = step_value(h_cur, cfg.height_step, cfg.height_cap, dn_new);
            radius_next   = step_value(r_cur, cfg.radius_step, cfg.radius_cap, dn_new);
            phase_next    = ph_cur + cfg.phase_step[PHASE_BITS-1:0];
            down_next     = dn_new;
            s1_next.valid  = 1'b1;
            s1_next.radius = radius_next;
            s1_next.idx    = ph_cur[PHASE_BITS-1 -: IDX_W];
            s1_next.z      = height_next;
            s1_next.desc   = dn_new;
        end
        else if (s1_ready)
        begin
            s1_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            radius_reg <= RADIUS_RESET;
            phase_reg  <= '0;
            down_reg   <= 1'b0;
            s1_reg     <= '0;
        end
        else
        begin
            height_reg <= height_next;
            radius_reg <= radius_next;
            phase_reg  <= phase_next;
            down_reg   <= down_next;
            s1_reg     <= s1_next;
        end
    end

endmodule

// ===== src/ssg_trig.sv =====
// Sine/cosine lookup stage, then scale-and-round into the output register.
module ssg_trig (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssg_pkg::ssg_sample_t              s1,
    output logic                              s1_ready,
    output ssg_pkg::ssg_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ssg_pkg::OUT_W-1:0]  x_pos,
    output logic signed [ssg_pkg::OUT_W-1:0]  y_pos,
    output logic [ssg_pkg::POS_W-1:0]         z_pos,
    output logic                              descending
);
    import ssg_pkg::*;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] radius;
        logic [MAG_W-1:0] sin_mag;
        logic             sin_neg;
        logic [MAG_W-1:0] cos_mag;
        logic             cos_neg;
        logic [POS_W-1:0] z;
        logic             desc;
    } lookup_t;

    lookup_t          s2_reg, s2_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] x_reg, x_next;
    logic [OUT_W-1:0] y_reg, y_next;
    logic [POS_W-1:0] z_reg;
    logic             desc_reg;
    logic             s2_ready;
    logic [IDX_W-1:0] cos_idx;

    // quarter-wave fold: magnitude of table entry idx
    function automatic logic [MAG_W-1:0] sine_mag(input logic [IDX_W-1:0] idx);
        logic [QTR_W-1:0] low;
        logic [MAG_W-1:0] mag;
        low = idx[QTR_W-1:0];
        if (!idx[QTR_W])
            mag = SINE_ROM[low];
        else if (low == '0)
            mag = SINE_PEAK;
        else
            mag = SINE_ROM[QTR_W'(0) - low];
        return mag;
    endfunction

    // round half away from zero of radius*mag/2^30, sign applied after
    function automatic logic [OUT_W-1:0] scale(
        input logic [POS_W-1:0] r,
        input logic [MAG_W-1:0] mag,
        input logic             neg
    );
        logic [POS_W+MAG_W:0] prod;
        logic [OUT_W-1:0]     q;
        prod = (POS_W+MAG_W+1)'(r) * (POS_W+MAG_W+1)'(mag)
             + ((POS_W+MAG_W+1)'(1) << 29);
        q    = prod[30 +: OUT_W];
        return neg ? (OUT_W'(0) - q) : q;
    endfunction

    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_ready  = !s2_reg.valid || s2_ready;
    assign cos_idx   = s1.idx + IDX_W'(QTR);
    assign status.s2_valid = s2_reg.valid;

    always_comb
    begin
        s2_next = s2_reg;
        if (s1_ready)
        begin
            s2_next.valid   = s1.valid;
            s2_next.radius  = s1.radius;
            s2_next.sin_mag = sine_mag(s1.idx);
            s2_next.sin_neg = s1.idx[IDX_W-1];
            s2_next.cos_mag = sine_mag(cos_idx);
            s2_next.cos_neg = cos_idx[IDX_W-1];
            s2_next.z       = s1.z;
            s2_next.desc    = s1.desc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        if (s2_ready)
        begin
            out_valid_next = s2_reg.valid;
            x_next         = scale(s2_reg.radius, s2_reg.sin_mag, s2_reg.sin_neg);
            y_next         = scale(s2_reg.radius, s2_reg.cos_mag, s2_reg.cos_neg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            desc_reg      <= 1'b0;
        end
        else
        begin
            s2_reg        <= s2_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            if (s2_ready)
            begin
                z_reg    <= s2_reg.z;
                desc_reg <= s2_reg.desc;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_pos      = x_reg;
    assign y_pos      = y_reg;
    assign z_pos      = z_reg;
    assign descending = desc_reg;

endmodule
